// File: rtl/core/can_bit_timing_search_core_defines.svh
// ---------------------------------------------------------------------------
// CAN bit timing search core: assertion macros
// Immediate-implication and next-cycle checks, compiled out for synthesis.
// ---------------------------------------------------------------------------
`ifndef CAN_BIT_TIMING_SEARCH_CORE_DEFINES_SVH
`define CAN_BIT_TIMING_SEARCH_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// Check that cons holds in the same cycle as ante.
`define CBTS_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cbts check failed");

// Check that cons holds in the cycle after ante.
`define CBTS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cbts check failed");

`else

`define CBTS_ASSERT_IMPLIES(label, clk, rst, ante, cons)

`define CBTS_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// File: rtl/core/cbts_pkg.sv
// ---------------------------------------------------------------------------
// CAN bit timing search package
// Shared widths, constants and control/status types.
// ---------------------------------------------------------------------------
package cbts_pkg;

   localparam int CLK_W         = 28;
   localparam int RATE_W        = 32;
   // A bitrate that passes the clock/4 check fits in this many bits.
   localparam int RATE_N_W      = CLK_W - 2;
   localparam int QUANTA_START  = 16;
   localparam int QUANTA_MIN    = 4;

   localparam logic [CLK_W-1:0] CLOCK_RESET = 28'd80000000;

   // Configuration port
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;
   localparam logic CSR_IDX_CLOCK_HZ = 1'b0;

   // Control from the sequencer to the shared accumulate/compare unit.
   typedef struct packed {
      logic start;   // clear accumulator and prescaler
      logic step;    // add one more product and compare
   } scan_ctrl_type;

   // Status back from the unit.
   typedef struct packed {
      logic hit;     // accumulated product equals the clock
      logic miss;    // passed the clock or ran out of prescalers
   } scan_status_type;

endpackage

// File: rtl/core/cbts_scan_unit.sv
// ---------------------------------------------------------------------------
// CAN bit timing search: prescaler scan unit
// Adds the bit-rate product once per cycle while stepped and compares with the clock.
// ---------------------------------------------------------------------------
module cbts_scan_unit #(
   parameter int PRESCALER_LIMIT = 512,
   parameter int PROD_W          = 35,
   localparam int PRESC_W        = $clog2(PRESCALER_LIMIT + 1),
   localparam int SUM_W          = PROD_W + 1
) (
   input  logic                          clock,
   input  cbts_pkg::scan_ctrl_type       ctrl,
   input  logic [PROD_W-1:0]             prod,
   input  logic [cbts_pkg::CLK_W-1:0]    clock_hz,
   output cbts_pkg::scan_status_type     status,
   output logic [PRESC_W-1:0]            presc
);

   logic [cbts_pkg::CLK_W-1:0] acc_ff;
   logic [cbts_pkg::CLK_W-1:0] acc_in;
   logic [PRESC_W-1:0]         presc_ff;
   logic [PRESC_W-1:0]         presc_in;
   logic [SUM_W-1:0]           sum;
   logic [PRESC_W-1:0]         presc_nx;

   assign sum      = SUM_W'(acc_ff) + SUM_W'(prod);
   assign presc_nx = presc_ff + PRESC_W'(1);

   always_comb begin
      status.hit  = ctrl.step && (sum == SUM_W'(clock_hz));
      status.miss = ctrl.step && !status.hit &&
                    ((sum > SUM_W'(clock_hz)) ||
                     (presc_nx == PRESC_W'(PRESCALER_LIMIT)));
   end

   // prescaler that the current step tries
   assign presc = presc_nx;

   always_comb begin
      acc_in   = acc_ff;
      presc_in = presc_ff;
      if (ctrl.start) begin
         acc_in   = '0;
         presc_in = '0;
      end else if (ctrl.step) begin
         // taken on every step, even once the sum has passed the clock
         acc_in   = sum[cbts_pkg::CLK_W-1:0];
         presc_in = presc_nx;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff   <= acc_in;
      presc_ff <= presc_in;
   end

endmodule

// File: rtl/core/can_bit_timing_search_core.sv
// ---------------------------------------------------------------------------
// CAN bit timing search core
// Flow: a bitrate above clock/4 goes from the check straight to its result
// word. Otherwise the sequencer, for each count tried, checks the bound and
// direction, forms the product and steps through the prescalers, until a
// hit or until the counts run out.
// Throughput: one word at a time; the single add/compare unit sets the pace.
// Reset: synchronous; clock_hz returns to 80 MHz, both channels empty.
// ---------------------------------------------------------------------------
`include "can_bit_timing_search_core_defines.svh"

module can_bit_timing_search_core #(
   parameter int PRESCALER_LIMIT = 512,
   parameter int QUANTA_LIMIT    = 385,
   localparam int PRESC_W = $clog2(PRESCALER_LIMIT + 1),
   localparam int QC_W    = $clog2(QUANTA_LIMIT + 1),
   localparam int SEG1_W  = $clog2(QUANTA_LIMIT - QUANTA_LIMIT / 4),
   localparam int SEG2_W  = $clog2(QUANTA_LIMIT / 4 + 1)
) (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [cbts_pkg::RATE_W-1:0]       req_bitrate,
   // response channel
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_found,
   output logic [PRESC_W-1:0]                rsp_prescaler,
   output logic [QC_W-1:0]                   rsp_quanta_count,
   output logic [SEG1_W-1:0]                 rsp_segment_one,
   output logic [SEG2_W-1:0]                 rsp_segment_two,
   // configuration port
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [cbts_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [cbts_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [cbts_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);

   // Count register must hold one past the limit and one below the minimum.
   localparam int CNT_W  = $clog2(QUANTA_LIMIT + 2);
   localparam int PROD_W = cbts_pkg::RATE_N_W + CNT_W;

   // Sequencer states
   localparam logic [2:0] ST_IDLE   = 3'd0;  // wait for a word
   localparam logic [2:0] ST_CHECK  = 3'd1;  // bitrate against clock/4
   localparam logic [2:0] ST_TOP    = 3'd2;  // bound and direction of count
   localparam logic [2:0] ST_PROD   = 3'd3;  // form bitrate * count
   localparam logic [2:0] ST_SCAN   = 3'd4;  // step prescalers
   localparam logic [2:0] ST_FINISH = 3'd5;  // hand result to output stage

   logic [2:0]                      state_ff, state_in;
   logic [cbts_pkg::CLK_W-1:0]      clock_hz_ff, clock_hz_in;
   logic [cbts_pkg::RATE_W-1:0]     rate_ff, rate_in;
   logic [CNT_W-1:0]                cnt_ff, cnt_in;
   logic                            down_ff, down_in;
   logic [PROD_W-1:0]               prod_ff, prod_in;
   logic                            found_ff, found_in;
   logic [PRESC_W-1:0]              presc_res_ff, presc_res_in;

   logic                            rsp_valid_ff, rsp_valid_in;
   logic                            rsp_found_ff;
   logic [PRESC_W-1:0]              rsp_prescaler_ff;
   logic [QC_W-1:0]                 rsp_quanta_count_ff;
   logic [SEG1_W-1:0]               rsp_segment_one_ff;
   logic [SEG2_W-1:0]               rsp_segment_two_ff;

   logic                            load_rsp;
   logic                            csr_write;
   logic [cbts_pkg::RATE_N_W-1:0]   rate_n;
   logic [PROD_W-1:0]               prod_mul;
   logic [CNT_W-1:0]                seg2_cnt;
   logic [CNT_W-1:0]                seg1_cnt;

   cbts_pkg::scan_ctrl_type         scan_ctrl;
   cbts_pkg::scan_status_type       scan_status;
   logic [PRESC_W-1:0]              scan_presc;

   // ------------------------------------------------------------------------
   // Configuration register: clock_hz at byte address 0. Any address with
   // bit 2 set lies beyond the register list; drop those writes, read zero.
   // ------------------------------------------------------------------------
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready &&
                       (csr_paddr[2] == cbts_pkg::CSR_IDX_CLOCK_HZ);

   always_comb begin
      clock_hz_in = clock_hz_ff;
      if (csr_write) begin
         clock_hz_in = csr_pwdata[cbts_pkg::CLK_W-1:0];
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         cbts_pkg::CSR_IDX_CLOCK_HZ: begin
            csr_prdata = cbts_pkg::CSR_DATA_W'(clock_hz_ff);
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   // ------------------------------------------------------------------------
   // Datapath helpers. Past the clock/4 check the bitrate fits RATE_N_W bits,
   // so one narrow multiplier forms the product for each count tried.
   // ------------------------------------------------------------------------
   assign rate_n   = rate_ff[cbts_pkg::RATE_N_W-1:0];
   assign prod_mul = PROD_W'(rate_n) * PROD_W'(cnt_ff);

   // tseg2 = count/4, tseg1 = count - tseg2 - 1
   assign seg2_cnt = cnt_ff >> 2;
   assign seg1_cnt = cnt_ff - seg2_cnt - CNT_W'(1);

   // Shared accumulate/compare unit: in each scan-state cycle it tries the
   // next prescaler, adding the product again and comparing with the clock.
   cbts_scan_unit #(
      .PRESCALER_LIMIT (PRESCALER_LIMIT),
      .PROD_W          (PROD_W)
   ) u_scan (
      .clock    (clock),
      .ctrl     (scan_ctrl),
      .prod     (prod_ff),
      .clock_hz (clock_hz_ff),
      .status   (scan_status),
      .presc    (scan_presc)
   );

   // ------------------------------------------------------------------------
   // Sequencer. The count starts at 16 and climbs; once the product of the
   // start count or of the count just tried passes clock/2, restart at 15
   // and count down. A count outside 4 .. QUANTA_LIMIT ends with a miss.
   // ------------------------------------------------------------------------
   always_comb begin
      state_in     = state_ff;
      rate_in      = rate_ff;
      cnt_in       = cnt_ff;
      down_in      = down_ff;
      prod_in      = prod_ff;
      found_in     = found_ff;
      presc_res_in = presc_res_ff;
      scan_ctrl    = '0;
      load_rsp     = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               rate_in  = req_bitrate;
               cnt_in   = CNT_W'(cbts_pkg::QUANTA_START);
               down_in  = 1'b0;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (rate_ff > cbts_pkg::RATE_W'(clock_hz_ff >> 2)) begin
               // fail at once
               found_in = 1'b0;
               state_in = ST_FINISH;
            end else begin
               // seed the direction test with the product of the first count
               prod_in  = PROD_W'(rate_n) * PROD_W'(cbts_pkg::QUANTA_START);
               state_in = ST_TOP;
            end
         end
         ST_TOP: begin
            if ((cnt_ff < CNT_W'(cbts_pkg::QUANTA_MIN)) ||
                (cnt_ff > CNT_W'(QUANTA_LIMIT))) begin
               found_in = 1'b0;
               state_in = ST_FINISH;
            end else begin
               if (!down_ff && (prod_ff > PROD_W'(clock_hz_ff >> 1))) begin
                  // turn around below the start count
                  down_in = 1'b1;
                  cnt_in  = CNT_W'(cbts_pkg::QUANTA_START - 1);
               end
               state_in = ST_PROD;
            end
         end
         ST_PROD: begin
            prod_in         = prod_mul;
            scan_ctrl.start = 1'b1;
            state_in        = ST_SCAN;
         end
         ST_SCAN: begin
            scan_ctrl.step = 1'b1;
            if (scan_status.hit) begin
               found_in     = 1'b1;
               presc_res_in = scan_presc;
               state_in     = ST_FINISH;
            end else if (scan_status.miss) begin
               // advance to the next count in the current direction
               cnt_in   = down_ff ? (cnt_ff - CNT_W'(1)) : (cnt_ff + CNT_W'(1));
               state_in = ST_TOP;
            end
         end
         ST_FINISH: begin
            // hold until the output stage is free
            if (!rsp_valid_ff || !rsp_stall) begin
               load_rsp = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // ready only between words
   assign req_stall = (state_ff != ST_IDLE);

   // Output stage: keep a finished word until the far side takes it.
   assign rsp_valid_in = load_rsp || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         clock_hz_ff  <= cbts_pkg::CLOCK_RESET;
         rsp_valid_ff <= 1'b0;
         down_ff      <= 1'b0;
         found_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clock_hz_ff  <= clock_hz_in;
         rsp_valid_ff <= rsp_valid_in;
         down_ff      <= down_in;
         found_ff     <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      rate_ff      <= rate_in;
      cnt_ff       <= cnt_in;
      prod_ff      <= prod_in;
      presc_res_ff <= presc_res_in;
      if (load_rsp) begin
         rsp_found_ff        <= found_ff;
         rsp_prescaler_ff    <= found_ff ? presc_res_ff : '0;
         rsp_quanta_count_ff <= found_ff ? QC_W'(cnt_ff) : '0;
         rsp_segment_one_ff  <= found_ff ? SEG1_W'(seg1_cnt) : '0;
         rsp_segment_two_ff  <= found_ff ? SEG2_W'(seg2_cnt) : '0;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_found        = rsp_found_ff;
   assign rsp_prescaler    = rsp_prescaler_ff;
   assign rsp_quanta_count = rsp_quanta_count_ff;
   assign rsp_segment_one  = rsp_segment_one_ff;
   assign rsp_segment_two  = rsp_segment_two_ff;

   // ------------------------------------------------------------------------
   // Checks
   // ------------------------------------------------------------------------
   `CBTS_ASSERT_IMPLIES(a_found_count_range, clock, reset, rsp_valid && rsp_found, (rsp_quanta_count >= QC_W'(cbts_pkg::QUANTA_MIN)) && (rsp_quanta_count <= QC_W'(QUANTA_LIMIT)))
   `CBTS_ASSERT_IMPLIES(a_found_segments_sum, clock, reset, rsp_valid && rsp_found, (rsp_segment_one + rsp_segment_two + 1) == rsp_quanta_count)
   `CBTS_ASSERT_IMPLIES(a_miss_fields_zero, clock, reset, rsp_valid && !rsp_found, (rsp_prescaler == '0) && (rsp_quanta_count == '0))
   `CBTS_ASSERT_IMPLIES(a_scan_count_range, clock, reset, state_ff == ST_SCAN, (cnt_ff >= CNT_W'(cbts_pkg::QUANTA_MIN)) && (cnt_ff <= CNT_W'(QUANTA_LIMIT)))
   `CBTS_ASSERT_NEXT(a_hit_goes_finish, clock, reset, (state_ff == ST_SCAN) && scan_status.hit, (state_ff == ST_FINISH) && found_ff)

endmodule
